// ===== design/lppc_pkg.sv =====
// Shared types, constants and tables for the lidar polar-to-Cartesian block.
// No dependencies; every other design file refers to this package by scoped names.
package lppc_pkg;

    localparam int TRIG_BITS        = 16;
    localparam int LASERS_PER_BLOCK = 32;
    localparam int CORDIC_STEPS     = 20;
    localparam int CORDIC_LAT       = CORDIC_STEPS + 1;
    localparam int BACK_LAT         = CORDIC_LAT + 3;
    localparam int CORDIC_GAIN      = 652032875;
    localparam int XW               = 34;
    localparam int ZW               = 32;
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_AW          = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW          = $clog2(FIFO_DEPTH + 1);

    // azimuth phase = floor((az * 2^T + 18000) / 36000), by reciprocal
    localparam int    AZ_SHIFT = 16;
    localparam int    AZ_W     = TRIG_BITS + 17;
    localparam int    AZ_HALF  = 18000;
    localparam int    AZ_TURN  = 36000;
    localparam longint AZ_MUL_L = (longint'(1) << (TRIG_BITS + AZ_SHIFT)) / AZ_TURN;
    localparam logic [TRIG_BITS:0] AZ_MUL = AZ_MUL_L[TRIG_BITS:0];

    localparam longint ELEV_TURN = 226800;
    localparam int     EL_IDX_W  = 6;

    localparam logic [15:0] UPPER_CODE_RST = 16'hEEFF;
    localparam logic [15:0] LOWER_CODE_RST = 16'hDDFF;

    localparam logic CFG_UPPER = 1'b0;
    localparam logic CFG_LOWER = 1'b1;

    localparam logic signed [XW-1:0] Q15_MAX = XW'(32767);
    localparam logic signed [XW-1:0] Q15_MIN = -XW'(32768);

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} t_quad;

    typedef logic [TRIG_BITS-1:0] t_phase;
    typedef t_phase t_el_tab [2**EL_IDX_W];

    typedef struct packed {
        t_phase      az_ph;
        t_phase      el_ph;
        logic [15:0] raw_dist;
        logic [4:0]  lidx;
    } t_work;

    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
    };

    // elevation phase for {lower group, laser index}; evaluated at elaboration
    function automatic t_el_tab build_el_tab();
        t_el_tab tab;
        longint  k;
        longint  n;
        for (int i = 0; i < 2**EL_IDX_W; i++) begin
            k = longint'(i & 31);
            if (i >= 32) begin
                k = k - LASERS_PER_BLOCK;
            end
            n = 1260 + k * 268 + ELEV_TURN;
            tab[i] = t_phase'(((n << TRIG_BITS) + ELEV_TURN / 2) / ELEV_TURN);
        end
        return tab;
    endfunction

    localparam t_el_tab EL_TAB = build_el_tab();

    // round Q2.30 to Q1.15 and saturate
    function automatic logic signed [15:0] to_q15(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        r = (v + XW'(16384)) >>> 15;
        if (r > Q15_MAX) begin
            r = Q15_MAX;
        end else if (r < Q15_MIN) begin
            r = Q15_MIN;
        end
        return r[15:0];
    endfunction

endpackage

// ===== design/lppc_front.sv =====
// Front end: code registers, return classification and phase computation.
// Depends on lppc_pkg; feeds lppc_fifo.
module lppc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [15:0]          i_block_code,
    input  logic [15:0]          i_azimuth,
    input  logic [4:0]           i_laser_index,
    input  logic [15:0]          i_raw_distance,
    input  logic                 i_full,
    output logic                 o_push,
    output lppc_pkg::t_work      o_work
);

    logic [15:0] r_upper;
    logic [15:0] r_lower;

    logic                          r_va;
    logic                          r_vb;
    logic [15:0]                   r_az;
    logic [lppc_pkg::TRIG_BITS:0]  r_qe;
    lppc_pkg::t_phase              r_el;
    logic [15:0]                   r_d;
    logic [4:0]                    r_li;
    lppc_pkg::t_work               r_work;

    logic                          w_adv;
    logic                          w_hit_u;
    logic                          w_hit_l;
    logic [lppc_pkg::AZ_W-1:0]     w_prod;
    logic [lppc_pkg::AZ_W-1:0]     w_x;
    logic [lppc_pkg::AZ_W-1:0]     w_r;
    lppc_pkg::t_phase              n_azph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= lppc_pkg::UPPER_CODE_RST;
            r_lower <= lppc_pkg::LOWER_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lppc_pkg::CFG_UPPER: r_upper <= i_cfg_data;
                lppc_pkg::CFG_LOWER: r_lower <= i_cfg_data;
                default:             r_upper <= r_upper;
            endcase
        end
    end

    assign w_adv   = !r_vb || !i_full;
    assign o_ready = w_adv;
    assign w_hit_u = (i_block_code == r_upper);
    assign w_hit_l = (i_block_code == r_lower);
    assign w_prod  = lppc_pkg::AZ_W'(i_azimuth) * lppc_pkg::AZ_W'(lppc_pkg::AZ_MUL);

    // estimate is low by at most two; fix it from the remainder
    assign w_x = {1'b0, r_az, {lppc_pkg::TRIG_BITS{1'b0}}} + lppc_pkg::AZ_W'(lppc_pkg::AZ_HALF);
    assign w_r = w_x - lppc_pkg::AZ_W'(r_qe) * lppc_pkg::AZ_W'(lppc_pkg::AZ_TURN);

    always_comb begin
        priority if (w_r >= lppc_pkg::AZ_W'(2 * lppc_pkg::AZ_TURN)) begin
            n_azph = r_qe[lppc_pkg::TRIG_BITS-1:0] + lppc_pkg::TRIG_BITS'(2);
        end else if (w_r >= lppc_pkg::AZ_W'(lppc_pkg::AZ_TURN)) begin
            n_azph = r_qe[lppc_pkg::TRIG_BITS-1:0] + lppc_pkg::TRIG_BITS'(1);
        end else begin
            n_azph = r_qe[lppc_pkg::TRIG_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (w_adv) begin
            // drop returns whose code matches neither group
            r_va <= i_valid && (w_hit_u || w_hit_l);
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_az  <= i_azimuth;
            r_qe  <= w_prod[lppc_pkg::AZ_W-1:lppc_pkg::AZ_SHIFT];
            r_el  <= lppc_pkg::EL_TAB[{!w_hit_u, i_laser_index}];
            r_d   <= i_raw_distance;
            r_li  <= i_laser_index;
            r_work.az_ph    <= n_azph;
            r_work.el_ph    <= r_el;
            r_work.raw_dist <= r_d;
            r_work.lidx     <= r_li;
        end
    end

    assign o_push = r_vb && !i_full;
    assign o_work = r_work;

endmodule

// ===== design/lppc_fifo.sv =====
// Short queue that decouples the front end from the trig/multiply back end.
// Depends on lppc_pkg.
module lppc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lppc_pkg::t_work i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output lppc_pkg::t_work o_data
);

    lppc_pkg::t_work                  r_mem [lppc_pkg::FIFO_DEPTH];
    logic [lppc_pkg::FIFO_AW-1:0]     r_wr;
    logic [lppc_pkg::FIFO_AW-1:0]     r_rd;
    logic [lppc_pkg::FIFO_CW-1:0]     r_cnt;

    assign o_full  = (r_cnt == lppc_pkg::FIFO_CW'(lppc_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + lppc_pkg::FIFO_CW'(i_push) - lppc_pkg::FIFO_CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= lppc_pkg::FIFO_CW'(lppc_pkg::FIFO_DEPTH))
        else $error("queue count out of range");
    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count did not follow push");

endmodule

// ===== design/lppc_cordic.sv =====
// Pipelined rotation CORDIC: phase in, Q1.15 sine and cosine out.
// Depends on lppc_pkg; the pipeline advances only while i_en is high.
module lppc_cordic (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  lppc_pkg::t_phase        i_phase,
    output logic signed [15:0]      o_sin,
    output logic signed [15:0]      o_cos
);

    localparam int XW = lppc_pkg::XW;
    localparam int ZW = lppc_pkg::ZW;
    localparam int N  = lppc_pkg::CORDIC_STEPS;

    logic [31:0]           w_p;
    logic signed [XW-1:0]  r_x [N];
    logic signed [XW-1:0]  r_y [N];
    logic signed [ZW-1:0]  r_z [N];
    logic [1:0]            r_quad [N];
    logic signed [XW-1:0]  w_s;
    logic signed [XW-1:0]  w_c;
    logic signed [15:0]    r_sin;
    logic signed [15:0]    r_cos;

    assign w_p = {i_phase, {(32 - lppc_pkg::TRIG_BITS){1'b0}}};

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [XW-1:0] w_xi;
        logic signed [XW-1:0] w_yi;
        logic signed [ZW-1:0] w_zi;
        logic [1:0]           w_qi;
        logic signed [ZW-1:0] w_at;

        if (i == 0) begin : g_first
            assign w_xi = XW'(lppc_pkg::CORDIC_GAIN);
            assign w_yi = '0;
            assign w_zi = $signed({2'b00, w_p[29:0]});
            assign w_qi = w_p[31:30];
        end else begin : g_next
            assign w_xi = r_x[i-1];
            assign w_yi = r_y[i-1];
            assign w_zi = r_z[i-1];
            assign w_qi = r_quad[i-1];
        end

        assign w_at = $signed(lppc_pkg::ATAN_TURN[i]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_zi >= 0) begin
                    r_x[i] <= w_xi - (w_yi >>> i);
                    r_y[i] <= w_yi + (w_xi >>> i);
                    r_z[i] <= w_zi - w_at;
                end else begin
                    r_x[i] <= w_xi + (w_yi >>> i);
                    r_y[i] <= w_yi - (w_xi >>> i);
                    r_z[i] <= w_zi + w_at;
                end
                r_quad[i] <= w_qi;
            end
        end
    end

    // fold the quadrant back by symmetry
    always_comb begin
        unique case (lppc_pkg::t_quad'(r_quad[N-1]))
            lppc_pkg::QUAD_0: begin w_s = r_y[N-1];  w_c = r_x[N-1];  end
            lppc_pkg::QUAD_1: begin w_s = r_x[N-1];  w_c = -r_y[N-1]; end
            lppc_pkg::QUAD_2: begin w_s = -r_y[N-1]; w_c = -r_x[N-1]; end
            lppc_pkg::QUAD_3: begin w_s = -r_x[N-1]; w_c = r_y[N-1];  end
            default:          begin w_s = r_y[N-1];  w_c = r_x[N-1];  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= lppc_pkg::to_q15(w_s);
            r_cos <= lppc_pkg::to_q15(w_c);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== design/lppc_back.sv =====
// Back end: two CORDIC pipelines, range products and output register.
// Depends on lppc_pkg and lppc_cordic; pulls work items from lppc_fifo.
module lppc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_work_valid,
    input  lppc_pkg::t_work      i_work,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [16:0]          o_x,
    output logic [16:0]          o_y,
    output logic [16:0]          o_z,
    output logic [4:0]           o_idx
);

    localparam int CL = lppc_pkg::CORDIC_LAT;
    localparam int BL = lppc_pkg::BACK_LAT;

    logic                 w_en;
    logic [BL-1:0]        r_bv;
    logic [15:0]          r_d  [CL];
    logic [4:0]           r_li [CL];

    logic signed [15:0]   w_saz;
    logic signed [15:0]   w_caz;
    logic signed [15:0]   w_sel;
    logic signed [15:0]   w_cel;

    logic signed [32:0]   r_pc;
    logic signed [32:0]   r_ps;
    logic signed [15:0]   r_saz;
    logic signed [15:0]   r_caz;
    logic [4:0]           r_li1;
    logic signed [48:0]   r_px;
    logic signed [48:0]   r_py;
    logic signed [32:0]   r_pz;
    logic [4:0]           r_li2;
    logic signed [48:0]   w_rx;
    logic signed [48:0]   w_ry;
    logic signed [32:0]   w_rz;
    logic [16:0]          r_ox;
    logic [16:0]          r_oy;
    logic [16:0]          r_oz;
    logic [4:0]           r_oi;

    // the whole pipe holds while a finished point waits
    assign w_en    = !r_bv[BL-1] || i_ready;
    assign o_pop   = w_en && i_work_valid;
    assign o_valid = r_bv[BL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (w_en) begin
            r_bv <= {r_bv[BL-2:0], i_work_valid};
        end
    end

    lppc_cordic u_az (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (i_work.az_ph),
        .o_sin   (w_saz),
        .o_cos   (w_caz)
    );

    lppc_cordic u_el (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (i_work.el_ph),
        .o_sin   (w_sel),
        .o_cos   (w_cel)
    );

    for (genvar i = 0; i < CL; i++) begin : g_line
        if (i == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_d[i]  <= i_work.raw_dist;
                    r_li[i] <= i_work.lidx;
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_d[i]  <= r_d[i-1];
                    r_li[i] <= r_li[i-1];
                end
            end
        end
    end

    assign w_rx = r_px + (49'sd1 <<< 29);
    assign w_ry = r_py + (49'sd1 <<< 29);
    assign w_rz = r_pz + (33'sd1 <<< 14);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pc  <= $signed({1'b0, r_d[CL-1]}) * w_cel;
            r_ps  <= $signed({1'b0, r_d[CL-1]}) * w_sel;
            r_saz <= w_saz;
            r_caz <= w_caz;
            r_li1 <= r_li[CL-1];

            r_px  <= r_pc * r_saz;
            r_py  <= r_pc * r_caz;
            r_pz  <= r_ps;
            r_li2 <= r_li1;

            r_ox  <= w_rx[46:30];
            r_oy  <= w_ry[46:30];
            r_oz  <= w_rz[31:15];
            r_oi  <= r_li2;
        end
    end

    assign o_x   = r_ox;
    assign o_y   = r_oy;
    assign o_z   = r_oz;
    assign o_idx = r_oi;

    a_pop_only_when_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_bv[0])
        else $error("popped item not captured");
    a_stall_keeps_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (r_bv == $past(r_bv)))
        else $error("pipe advanced while output stalled");
    a_no_pop_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |-> !o_pop)
        else $error("pop during stall");

endmodule

// ===== design/lidar_point_polar_to_cartesian_top.sv =====
// Top level of the lidar polar-to-Cartesian converter.
// Depends on lppc_pkg, lppc_front, lppc_fifo and lppc_back.
//
// Usage:
//  - Slave stream carries one lidar return per item; master stream carries
//    one point (x, y, z in 2 mm units and the laser index) per kept item.
//  - Returns whose block code matches neither code register are dropped.
//  - Code registers are written through i_cfg_we / i_cfg_idx / i_cfg_data
//    (index 0 upper group, index 1 lower group) while the block is idle.
//  - Throughput: one item per cycle, sustained, while the master side takes.
//  - Path to o_m_axis_tvalid: an accepted item passes the classify stage,
//    the front register (azimuth correction), the queue, the CORDIC rotation
//    steps and their output register, the multiply registers and the output
//    register.
//  - A stall on i_m_axis_tready freezes the back pipeline; the four-entry
//    queue and front stages keep taking items until the queue fills.
//  - Reset (synchronous, active low) empties all stages and the queue and
//    loads the code registers with 0xEEFF and 0xDDFF.
module lidar_point_polar_to_cartesian_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // block_code[15:0], azimuth[31:16], laser_index[36:32], raw_distance[52:37]
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // x_pos[16:0], y_pos[33:17], z_pos[50:34], point_index[55:51]
    output logic [55:0] o_m_axis_tdata
);

    logic            w_full;
    logic            w_push;
    logic            w_pop;
    logic            w_qvalid;
    lppc_pkg::t_work w_fwork;
    lppc_pkg::t_work w_qwork;
    logic [16:0]     w_x;
    logic [16:0]     w_y;
    logic [16:0]     w_z;
    logic [4:0]      w_idx;

    lppc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_block_code   (i_s_axis_tdata[15:0]),
        .i_azimuth      (i_s_axis_tdata[31:16]),
        .i_laser_index  (i_s_axis_tdata[36:32]),
        .i_raw_distance (i_s_axis_tdata[52:37]),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_work         (w_fwork)
    );

    lppc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fwork),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_qwork)
    );

    lppc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (w_qvalid),
        .i_work       (w_qwork),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_x          (w_x),
        .o_y          (w_y),
        .o_z          (w_z),
        .o_idx        (w_idx)
    );

    assign o_m_axis_tdata = {w_idx, w_z, w_y, w_x};

endmodule

// ===== tb/sv/tb_lidar_point_polar_to_cartesian_top.sv =====
// Testbench for the lidar polar-to-Cartesian converter: drives returns on the
// slave stream, predicts each point with a bit-exact CORDIC model, checks the
// master stream. Depends on lppc_pkg and lidar_point_polar_to_cartesian_top.
`timescale 1ns / 100ps

module tb_lidar_point_polar_to_cartesian_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [15:0] raw_dist;
        logic [4:0]  lidx;
        logic [15:0] az;
        logic [15:0] code;
    } t_return;

    typedef struct {
        logic [16:0] x;
        logic [16:0] y;
        logic [16:0] z;
        logic [4:0]  idx;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = lppc_pkg::CFG_UPPER;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [55:0] o_m_axis_tdata;

    logic [15:0] upper_code;
    logic [15:0] lower_code;
    t_point      pending_points[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          stall_mode = 0;
    int          burst_left = 0;

    lidar_point_polar_to_cartesian_top u_dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_q15(longint v);
        longint r;
        r = fshift(v + 16384, 15);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic void sin_cos(input logic [15:0] phase, output longint s,
                                    output longint c);
        logic [31:0] p;
        longint      zz;
        longint      xx;
        longint      yy;
        longint      nx;
        p = {phase, 16'h0};
        zz = longint'(p[29:0]);
        xx = lppc_pkg::CORDIC_GAIN;
        yy = 0;
        for (int i = 0; i < lppc_pkg::CORDIC_STEPS; i++) begin
            if (zz >= 0) begin
                nx = xx - fshift(yy, i);
                yy = yy + fshift(xx, i);
                zz = zz - longint'(lppc_pkg::ATAN_TURN[i]);
            end else begin
                nx = xx + fshift(yy, i);
                yy = yy - fshift(xx, i);
                zz = zz + longint'(lppc_pkg::ATAN_TURN[i]);
            end
            xx = nx;
        end
        case (p[31:30])
            2'd0: begin s = round_q15(yy);  c = round_q15(xx);  end
            2'd1: begin s = round_q15(xx);  c = round_q15(-yy); end
            2'd2: begin s = round_q15(-yy); c = round_q15(-xx); end
            default: begin s = round_q15(-xx); c = round_q15(yy); end
        endcase
    endfunction

    // Returns 0 when the block code matches neither group.
    function automatic bit convert_return(input t_return r, output t_point pt);
        longint      k;
        longint      n;
        longint      ph;
        logic [15:0] az_ph;
        logic [15:0] el_ph;
        longint      saz, caz, sel, cel;
        longint      d;
        if (r.code == upper_code) k = r.lidx;
        else if (r.code == lower_code) k = longint'(r.lidx) - lppc_pkg::LASERS_PER_BLOCK;
        else return 0;
        ph = ((longint'(r.az) << 16) + 18000) / 36000;
        az_ph = ph[15:0];
        n = 1260 + k * 268 + lppc_pkg::ELEV_TURN;
        ph = ((n << 16) + lppc_pkg::ELEV_TURN / 2) / lppc_pkg::ELEV_TURN;
        el_ph = ph[15:0];
        sin_cos(az_ph, saz, caz);
        sin_cos(el_ph, sel, cel);
        d = r.raw_dist;
        pt.x = 17'(fshift(d * cel * saz + (longint'(1) << 29), 30));
        pt.y = 17'(fshift(d * cel * caz + (longint'(1) << 29), 30));
        pt.z = 17'(fshift(d * sel + 16384, 15));
        pt.idx = r.lidx;
        return 1;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver stall pattern: phases of always-ready, random, and mostly stalled.
    always @(posedge i_clk) begin
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: i_m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    end

    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected point %h", o_m_axis_tdata);
            end else begin
                want = pending_points.pop_front();
                if (o_m_axis_tdata[16:0] !== want.x || o_m_axis_tdata[33:17] !== want.y ||
                    o_m_axis_tdata[50:34] !== want.z || o_m_axis_tdata[55:51] !== want.idx) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%h y=%h z=%h idx=%0d got %h",
                                 want.x, want.y, want.z, want.idx, o_m_axis_tdata);
                end
            end
        end
    end

    // Send one return; holds tvalid across back-to-back items within a burst.
    task automatic send_return(input t_return r);
        t_point pt;
        int     gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {3'b0, r.raw_dist, r.lidx, r.az, r.code};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (convert_return(r, pt)) pending_points.push_back(pt);
    endtask

    task automatic go_idle();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_codes(input logic [15:0] up, input logic [15:0] lo);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= lppc_pkg::CFG_UPPER;
        i_cfg_data <= up;
        @(posedge i_clk);
        i_cfg_idx <= lppc_pkg::CFG_LOWER;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        upper_code = up;
        lower_code = lo;
    endtask

    function automatic t_return rand_return(input int pick);
        t_return r;
        r.code = (pick < 45) ? upper_code : (pick < 90) ? lower_code : 16'($urandom);
        r.az = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
        r.lidx = 5'($urandom);
        r.raw_dist = 16'($urandom);
        return r;
    endfunction

    task automatic test_directed();
        t_return r;
        write_codes(lppc_pkg::UPPER_CODE_RST, lppc_pkg::LOWER_CODE_RST);
        for (int i = 0; i < 20; i++) begin
            r.code = (i % 3 == 0) ? upper_code : (i % 3 == 1) ? lower_code : 16'h1234;
            r.az = (i < 4) ? 16'd0 : (i < 8) ? 16'd35999 : (i < 10) ? 16'hFFFF :
                   16'(i * 4500);
            r.lidx = (i[0]) ? 5'd31 : 5'd0;
            r.raw_dist = (i[1]) ? 16'hFFFF : 16'(i);
            send_return(r);
        end
        go_idle();
    endtask

    task automatic test_equal_codes();
        t_return r;
        write_codes(16'h0000, 16'h0000);
        for (int i = 0; i < 5; i++) begin
            r = rand_return(0);
            send_return(r);
        end
        go_idle();
    endtask

    task automatic test_random(input logic [15:0] up, input logic [15:0] lo, input int count);
        write_codes(up, lo);
        for (int i = 0; i < count; i++) send_return(rand_return($urandom_range(0, 99)));
        go_idle();
    endtask

    initial begin
        upper_code = lppc_pkg::UPPER_CODE_RST;
        lower_code = lppc_pkg::LOWER_CODE_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_equal_codes();
        test_random(lppc_pkg::UPPER_CODE_RST, lppc_pkg::LOWER_CODE_RST, 400);
        test_random(16'hFFFF, 16'h0000, 350);
        test_random(16'($urandom), 16'($urandom), 380);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
